// ===== hw/rtl/scwm_pkg.sv =====
// Shared types and constants for the sigma-clipped window mean unit.
// No dependencies; imported by the result interface, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scwm_pkg;

  // Fixed field widths of the register and the result request
  localparam int CLIP_W   = 12;
  localparam int RESULT_W = 24;
  localparam int KEPT_W   = 15;

  // Clip factor after reset: 1.5 in unsigned Q4.8
  localparam logic [CLIP_W-1:0] CLIP_RESET = 12'd384;

  // Arithmetic widths of the shared units
  localparam int DIV_W  = 64;            // dividend and quotient of the divider
  localparam int HALF_W = DIV_W / 2;     // variance is scaled in two halves
  localparam int MUL_W  = 34;            // signed operand width of the multiplier
  localparam int K2_W   = 2 * CLIP_W;    // clip factor squared, Q8.16
  localparam int KV_W   = K2_W + DIV_W;  // exact k^2 * var

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,      // taking samples into the store
    ST_DIV_MEAN,  // mean = sum / count
    ST_PASS1,     // sum of squared deviations
    ST_DIV_VAR,   // var = sum of squares / count
    ST_K2,        // k^2
    ST_KLO,       // k^2 * var, low half
    ST_KHI,       // k^2 * var, high half
    ST_KSUM,      // combine the halves
    ST_PASS2,     // clip test and kept sum
    ST_DIV_RES,   // kept mean
    ST_OUT        // result waits for the sink
  } scwm_state_e;

endpackage : scwm_pkg

`default_nettype wire

// ===== hw/rtl/scwm_if.sv =====
// Handshake channels of the sigma-clipped window mean unit: samples in, results out.
// Depends on scwm_pkg for the result field widths.
`timescale 1ns / 1ps
`default_nettype none

// Sample channel: one window sample per request
interface scwm_smp_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;
  logic                           sample_excluded;
  logic                           sample_last;

  modport source (output valid, sample_value, sample_excluded, sample_last, input ready);
  modport sink   (input valid, sample_value, sample_excluded, sample_last, output ready);
endinterface : scwm_smp_if

// Result channel: one request per closed window
interface scwm_res_if import scwm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] repaired_value;
  logic [KEPT_W-1:0]          kept_total;
  logic                       status;

  modport source (output valid, repaired_value, kept_total, status, input ready);
  modport sink   (input valid, repaired_value, kept_total, status, output ready);
endinterface : scwm_res_if

`default_nettype wire

// ===== hw/rtl/scwm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on scwm_pkg for the dividend width; shared by all divisions of the unit.
`timescale 1ns / 1ps
`default_nettype none

module scwm_div import scwm_pkg::*; #(
  parameter int DVW = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DVW-1:0]   divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  acc_q;   // dividend bits shift out, quotient bits shift in
  logic [DVW-1:0]    rem_q;
  logic [DVW-1:0]    dsr_q;

  logic [DVW:0]      rem_sh;
  logic              q_bit;
  logic [DVW:0]      rem_sub;

  // One trial subtraction per cycle
  always_comb begin
    rem_sh  = {rem_q, acc_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    q_bit   = (rem_sh >= {1'b0, dsr_q});
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[DIV_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule : scwm_div

`default_nettype wire

// ===== hw/rtl/sigma_clipped_window_mean_unit.sv =====
// Top level of the sigma-clipped window mean unit: sample store, sequencer, pass pipeline.
// Depends on scwm_pkg, scwm_smp_if, scwm_res_if and scwm_div.
`timescale 1ns / 1ps
`default_nettype none

// Samples are taken one per cycle; non-excluded ones go into the sample store
// (up to MAX_SAMPLES, the rest dropped). The request that carries the last flag
// closes the window, and the unit stops taking samples until the result has
// been taken. Three divisions run on the shared radix-2 divider, each with
// operand load, 64 quotient bits and done (mean, variance, kept mean). Two
// passes run over the store at one read a cycle through its single read port,
// each followed by pipeline drain and pass end. Four steps (three multiplies
// and a combine) scale the variance by the squared clip factor.
// An empty window answers with status 1 in the cycle after its last request.
// A window where every sample is clipped skips the last division and answers
// with status 1. The store needs no clearing after reset. clip_factor must be
// written only while the unit is idle; the unit itself does not enforce this.
module sigma_clipped_window_mean_unit import scwm_pkg::*; #(
  parameter int MAX_SAMPLES  = 16384,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CLIP_W-1:0] cfg_wdata_i,
  scwm_smp_if.sink               smp_i,
  scwm_res_if.source             res_o
);

  localparam int CW   = $clog2(MAX_SAMPLES + 1);  // counts up to MAX_SAMPLES
  localparam int AW   = $clog2(MAX_SAMPLES);      // store address
  localparam int SUMW = SAMPLE_WIDTH + CW;        // signed sum of a window
  localparam int DW   = SAMPLE_WIDTH + 1;         // deviation from the mean
  localparam int PW   = 2 * MUL_W;                // product width

  scwm_state_e state_q, state_d;

  logic [CLIP_W-1:0]              clip_q;
  logic [CW-1:0]                  cnt_q;
  logic signed [SUMW-1:0]         sum_q;
  logic [DIV_W-1:0]               sqsum_q;
  logic signed [SUMW-1:0]         ksum_q;
  logic [CW-1:0]                  kcnt_q;

  logic signed [SAMPLE_WIDTH-1:0] store_mem [MAX_SAMPLES];
  logic signed [SAMPLE_WIDTH-1:0] rd_data_q;

  logic [CW-1:0]                  rd_idx_q;
  logic                           va_q, vb_q, vc_q;
  logic signed [DW-1:0]           dev_q;
  logic signed [SAMPLE_WIDTH-1:0] xb_q, xc_q;
  logic [PW-1:0]                  mul_q;
  logic signed [DW-1:0]           mean_q;
  logic [DIV_W-1:0]               var_q;
  logic [K2_W-1:0]                k2_q;
  logic [K2_W+HALF_W-1:0]         kvlo_q;
  logic [DIV_W-1:0]               kv_q;
  logic                           kv_ovf_q;

  logic signed [RESULT_W-1:0]     res_val_q;
  logic [KEPT_W-1:0]              res_cnt_q;
  logic                           res_st_q;

  logic                           started_q;

  // Handshake and control strobes
  logic                  in_acc;
  logic                  out_acc;
  logic                  st_en;
  logic                  issue;
  logic                  pass_end;
  logic                  div_start;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;
  logic [DIV_W-1:0]      div_dividend;
  logic [CW-1:0]         div_divisor;
  logic                  div_neg;
  logic signed [MUL_W-1:0] mul_a, mul_b;

  logic [SUMW-1:0]       sum_mag;
  logic [SUMW-1:0]       ksum_mag;
  logic [DW-1:0]         mean_mag;
  logic [DIV_W-1:0]      res_signed;
  logic [KV_W-1:0]       kv_full;
  logic [DIV_W-1:0]      lhs;
  logic                  keep;

  assign in_acc   = smp_i.valid && smp_i.ready;
  assign out_acc  = res_o.valid && res_o.ready;
  assign st_en    = in_acc && !smp_i.sample_excluded && (cnt_q < CW'(MAX_SAMPLES));
  assign pass_end = (rd_idx_q == cnt_q) && !va_q && !vb_q && !vc_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && smp_i.sample_last) begin
          state_d = (st_en || (cnt_q != '0)) ? ST_DIV_MEAN : ST_OUT;
        end
      end
      ST_DIV_MEAN: if (div_done) state_d = ST_PASS1;
      ST_PASS1:    if (pass_end) state_d = ST_DIV_VAR;
      ST_DIV_VAR:  if (div_done) state_d = ST_K2;
      ST_K2:       state_d = ST_KLO;
      ST_KLO:      state_d = ST_KHI;
      ST_KHI:      state_d = ST_KSUM;
      ST_KSUM:     state_d = ST_PASS2;
      ST_PASS2: begin
        if (pass_end) state_d = (kcnt_q != '0) ? ST_DIV_RES : ST_OUT;
      end
      ST_DIV_RES:  if (div_done) state_d = ST_OUT;
      ST_OUT:      if (out_acc) state_d = ST_LOAD;
      default:     state_d = ST_LOAD;
    endcase
  end

  // Magnitudes for the signed divisions
  always_comb begin
    sum_mag  = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
    ksum_mag = ksum_q[SUMW-1] ? SUMW'(-ksum_q) : SUMW'(ksum_q);
  end

  // Sequencer outputs: handshakes, divider operands, multiplier operands
  always_comb begin
    smp_i.ready  = 1'b0;
    res_o.valid  = 1'b0;
    issue        = 1'b0;
    div_start    = 1'b0;
    div_dividend = sqsum_q;
    div_divisor  = cnt_q;
    div_neg      = 1'b0;
    mul_a        = MUL_W'(dev_q);
    mul_b        = MUL_W'(dev_q);
    unique case (state_q) inside
      ST_LOAD: smp_i.ready = 1'b1;
      ST_DIV_MEAN: begin
        div_start    = !started_q;
        div_dividend = DIV_W'(sum_mag);
        div_neg      = sum_q[SUMW-1];
      end
      ST_PASS1, ST_PASS2: issue = (rd_idx_q != cnt_q);
      ST_DIV_VAR: div_start = !started_q;
      ST_K2: begin
        mul_a = $signed({{(MUL_W-CLIP_W){1'b0}}, clip_q});
        mul_b = $signed({{(MUL_W-CLIP_W){1'b0}}, clip_q});
      end
      ST_KLO: begin
        mul_a = $signed({{(MUL_W-K2_W){1'b0}}, mul_q[K2_W-1:0]});
        mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, var_q[HALF_W-1:0]});
      end
      ST_KHI: begin
        mul_a = $signed({{(MUL_W-K2_W){1'b0}}, k2_q});
        mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, var_q[DIV_W-1:HALF_W]});
      end
      ST_KSUM: ;
      ST_DIV_RES: begin
        div_start    = !started_q;
        div_dividend = DIV_W'(ksum_mag);
        div_divisor  = kcnt_q;
        div_neg      = ksum_q[SUMW-1];
      end
      ST_OUT: res_o.valid = 1'b1;
      default: ;
    endcase
  end

  // Shared divider
  scwm_div #(
    .DVW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Quotient sign fix-up and the scaled-variance combine
  always_comb begin
    mean_mag   = div_quo[DW-1:0];
    res_signed = div_neg ? (DIV_W'(0) - div_quo) : div_quo;
    kv_full    = {mul_q[K2_W+HALF_W-1:0], {HALF_W{1'b0}}} + KV_W'(kvlo_q);
    lhs        = {mul_q[DIV_W-17:0], 16'b0};
    keep       = kv_ovf_q || (lhs <= kv_q);
  end

  // Sample store: one write port while loading, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_en) begin
      store_mem[cnt_q[AW-1:0]] <= smp_i.sample_value;
    end
    rd_data_q <= store_mem[rd_idx_q[AW-1:0]];
  end

  // Payload pipeline of the passes and the shared multiplier
  always_ff @(posedge clk_i) begin
    dev_q <= DW'(rd_data_q) - mean_q;
    xb_q  <= rd_data_q;
    xc_q  <= xb_q;
    mul_q <= PW'(mul_a) * PW'(mul_b);
  end

  // Window results that the sequencer captures along the way
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_MEAN && div_done) begin
      mean_q <= div_neg ? DW'(-$signed(mean_mag)) : $signed(mean_mag);
    end
    if (state_q == ST_DIV_VAR && div_done) begin
      var_q <= div_quo;
    end
    if (state_q == ST_KLO) begin
      k2_q <= mul_q[K2_W-1:0];
    end
    if (state_q == ST_KHI) begin
      kvlo_q <= mul_q[K2_W+HALF_W-1:0];
    end
    if (state_q == ST_KSUM) begin
      kv_q     <= kv_full[DIV_W-1:0];
      kv_ovf_q <= |kv_full[KV_W-1:DIV_W];
    end
    // Result register, loaded on the way into the output state
    if (state_d == ST_OUT && state_q != ST_OUT) begin
      if (state_q == ST_DIV_RES) begin
        res_val_q <= res_signed[RESULT_W-1:0];
        res_cnt_q <= kcnt_q[KEPT_W-1:0];
        res_st_q  <= STATUS_OK;
      end else begin
        res_val_q <= '0;
        res_cnt_q <= '0;
        res_st_q  <= STATUS_EMPTY;
      end
    end
  end

  // Control state, counters and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      clip_q    <= CLIP_RESET;
      cnt_q     <= '0;
      sum_q     <= '0;
      sqsum_q   <= '0;
      ksum_q    <= '0;
      kcnt_q    <= '0;
      rd_idx_q  <= '0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        clip_q <= cfg_wdata_i;
      end

      // Divider launch tracking
      if (div_start) begin
        started_q <= 1'b1;
      end else if (div_done) begin
        started_q <= 1'b0;
      end

      // Pass pipeline valids and read index
      va_q <= issue;
      vb_q <= va_q;
      vc_q <= vb_q;
      if (state_q == ST_PASS1 || state_q == ST_PASS2) begin
        if (issue) rd_idx_q <= rd_idx_q + 1'b1;
      end else begin
        rd_idx_q <= '0;
      end

      // Accumulation at the tail of each pass
      if (vc_q && state_q == ST_PASS1) begin
        sqsum_q <= sqsum_q + mul_q[DIV_W-1:0];
      end
      if (vc_q && state_q == ST_PASS2 && keep) begin
        ksum_q <= ksum_q + SUMW'(xc_q);
        kcnt_q <= kcnt_q + 1'b1;
      end

      // Loading, and clearing once the result is handed off
      if (out_acc) begin
        cnt_q   <= '0;
        sum_q   <= '0;
        sqsum_q <= '0;
        ksum_q  <= '0;
        kcnt_q  <= '0;
      end else if (st_en) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + SUMW'(smp_i.sample_value);
      end
    end
  end

  assign res_o.repaired_value = res_val_q;
  assign res_o.kept_total     = res_cnt_q;
  assign res_o.status         = res_st_q;

endmodule : sigma_clipped_window_mean_unit

`default_nettype wire
